@@ src/lrupf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page frame manager package
// Shared types, field widths and constants for the page frame manager.
// ----------------------------------------------------------------------------
package lrupf_pkg;

  // Fixed geometry of the page table and the frame pool.
  localparam int VIRTUAL_PAGES = 32;
  localparam int PAGE_W        = 5;
  localparam int MAX_FRAMES    = 32;
  localparam int FRAME_W       = 5;
  localparam int FREE_W        = 6;
  localparam int CFG_W         = 6;
  localparam int MISS_W        = 32;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4);

  // Operation codes carried by an input transaction.
  typedef enum logic [0:0] {
    OP_ACCESS = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  // Input transaction payload.
  typedef struct packed {
    op_t               operation;
    logic [PAGE_W-1:0] page_number;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_number;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [MISS_W-1:0]  miss_total;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_VICTIM,
    ST_EVICT,
    ST_FINISH
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic decide;
    logic scan_start;
    logic scan_step;
    logic victim_rd;
    logic evict;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_flush;
    logic is_hit;
    logic has_free;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage : lrupf_pkg
`default_nettype wire

@@ src/lrupf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page frame manager controller
// Sequences lookup, free frame allocation, the oldest-page scan, eviction
// and the final commit of each transaction.
// ----------------------------------------------------------------------------
module lrupf_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  lrupf_pkg::dp_status_t status,
  output logic                 idle,
  output lrupf_pkg::dp_cmd_t   cmd
);
  import lrupf_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    idle       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.is_flush) begin
          state_next = ST_FINISH;
        end else begin
          cmd.decide = 1'b1;
          if (status.is_hit || status.has_free) begin
            state_next = ST_FINISH;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        cmd.victim_rd = 1'b1;
        state_next    = ST_EVICT;
      end
      ST_EVICT: begin
        cmd.evict  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule : lrupf_ctrl
`default_nettype wire

@@ src/lrupf_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page frame manager datapath
// Holds the page table, the last-use memory, the counters, the oldest-page
// scan logic and the output register.
// ----------------------------------------------------------------------------
module lrupf_dp #(
  parameter int TIME_BITS = lrupf_pkg::TIME_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  lrupf_pkg::dp_cmd_t            cmd,
  output lrupf_pkg::dp_status_t         status,
  input  lrupf_pkg::in_item_t           in_data,
  input  wire                           cfg_write,
  input  wire [lrupf_pkg::CFG_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output lrupf_pkg::out_item_t          out_data
);
  import lrupf_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Page table: resident bits in flops, frame and last-use in memories.
  logic [VIRTUAL_PAGES-1:0] resident;
  logic [FRAME_W-1:0]       frame_mem [VIRTUAL_PAGES];
  logic [TIME_BITS-1:0]     last_use  [VIRTUAL_PAGES];

  logic [CFG_W-1:0]     frames_in_use;
  logic [FREE_W-1:0]    next_free;
  logic [TIME_BITS-1:0] access_clock;
  logic [MISS_W-1:0]    miss_counter;

  // Latched transaction and working registers.
  op_t                  op_q;
  logic [PAGE_W-1:0]    page_q;
  logic                 hit_q;
  logic [FRAME_W-1:0]   frame_q;
  logic                 ev_valid_q;
  logic [PAGE_W-1:0]    ev_page_q;
  logic [FRAME_W-1:0]   frame_rd_data;

  // Scan state.
  logic [PAGE_W:0]      scan_cnt;
  logic                 cmp_valid;
  logic [PAGE_W-1:0]    cmp_idx;
  logic [TIME_BITS-1:0] lu_rd_data;
  logic                 found;
  logic [TIME_BITS-1:0] oldest;
  logic [PAGE_W-1:0]    victim;

  logic [FREE_W-1:0]    frame_limit;
  logic [PAGE_W-1:0]    frame_rd_addr;
  logic                 scan_rd;
  logic                 better;

  // Effective frame count: zero acts as one, large values are clamped.
  always_comb begin
    if (frames_in_use == '0) begin
      frame_limit = FREE_W'(1);
    end else if (FREE_W'(frames_in_use) > FREE_W'(MAX_FRAMES)) begin
      frame_limit = FREE_W'(MAX_FRAMES);
    end else begin
      frame_limit = FREE_W'(frames_in_use);
    end
  end

  assign frame_rd_addr = cmd.victim_rd ? victim : in_data.page_number;
  assign scan_rd       = cmd.scan_step && (scan_cnt < (PAGE_W+1)'(VIRTUAL_PAGES));
  assign better        = cmp_valid && resident[cmp_idx] && (!found || (lu_rd_data < oldest));

  // Status toward the controller.
  always_comb begin
    status.is_flush  = (op_q == OP_FLUSH);
    status.is_hit    = resident[page_q];
    status.has_free  = (next_free < frame_limit);
    status.scan_last = cmp_valid && (cmp_idx == PAGE_W'(VIRTUAL_PAGES - 1));
    status.out_free  = !out_valid || !out_stall;
  end

  // Frame memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && (op_q == OP_ACCESS) && !hit_q) begin
      frame_mem[page_q] <= frame_q;
    end
    if (cmd.accept || cmd.victim_rd) begin
      frame_rd_data <= frame_mem[frame_rd_addr];
    end
  end

  // Last-use memory: written at commit, read one entry per scan cycle.
  always_ff @(posedge clk) begin
    if (cmd.commit && (op_q == OP_ACCESS)) begin
      last_use[page_q] <= access_clock;
    end
    if (scan_rd) begin
      lu_rd_data <= last_use[scan_cnt[PAGE_W-1:0]];
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      resident      <= '0;
      frames_in_use <= FRAMES_RESET;
      next_free     <= '0;
      access_clock  <= '0;
      miss_counter  <= '0;
      out_valid     <= 1'b0;
      scan_cnt      <= '0;
      cmp_valid     <= 1'b0;
      found         <= 1'b0;
    end else begin
      if (cfg_write) begin
        frames_in_use <= cfg_data;
      end

      // Miss accounting and free frame allocation.
      if (cmd.decide && !resident[page_q]) begin
        if (miss_counter != '1) begin
          miss_counter <= miss_counter + MISS_W'(1);
        end
        if (next_free < frame_limit) begin
          next_free <= next_free + FREE_W'(1);
        end
      end

      // Oldest-page scan, one entry per cycle, each compared in the cycle after its read.
      if (cmd.scan_start) begin
        scan_cnt  <= '0;
        cmp_valid <= 1'b0;
        found     <= 1'b0;
      end else if (cmd.scan_step) begin
        if (scan_rd) begin
          scan_cnt <= scan_cnt + (PAGE_W+1)'(1);
        end
        cmp_valid <= scan_rd;
        if (better) begin
          found <= 1'b1;
        end
      end

      if (cmd.evict && found) begin
        resident[victim] <= 1'b0;
      end

      // Commit: update the table and counters.
      if (cmd.commit) begin
        if (op_q == OP_FLUSH) begin
          resident     <= '0;
          next_free    <= '0;
          access_clock <= '0;
          miss_counter <= '0;
        end else begin
          resident[page_q] <= 1'b1;
          if (access_clock < TIME_MAX) begin
            access_clock <= access_clock + TIME_BITS'(1);
          end
        end
      end

      // Output register handshake.
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= in_data.operation;
      page_q <= in_data.page_number;
    end

    if (cmd.decide) begin
      hit_q      <= resident[page_q];
      ev_valid_q <= 1'b0;
      ev_page_q  <= '0;
      if (resident[page_q]) begin
        frame_q <= frame_rd_data;
      end else begin
        frame_q <= next_free[FRAME_W-1:0];
      end
    end

    if (cmd.scan_step) begin
      cmp_idx <= scan_cnt[PAGE_W-1:0];
      if (better) begin
        oldest <= lu_rd_data;
        victim <= cmp_idx;
      end
    end

    if (cmd.evict) begin
      if (found) begin
        frame_q    <= frame_rd_data;
        ev_valid_q <= 1'b1;
        ev_page_q  <= victim;
      end else begin
        frame_q <= '0;
      end
    end

    if (cmd.commit) begin
      if (op_q == OP_FLUSH) begin
        out_data <= '0;
      end else begin
        out_data.hit           <= hit_q;
        out_data.frame_number  <= frame_q;
        out_data.evicted_valid <= ev_valid_q;
        out_data.evicted_page  <= ev_page_q;
        out_data.miss_total    <= miss_counter;
      end
    end
  end

endmodule : lrupf_dp
`default_nettype wire

@@ src/lru_page_frame_manager.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page frame manager
// Maps virtual page accesses to physical frames with least-recently-used
// replacement; a flush transaction empties the table and clears counters.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one access or
//   flush per transaction. The output channel (out_valid, out_stall,
//   out_data) returns exactly one result per input transaction, in order.
//   cfg_write/cfg_data set the frame count; write it only while idle.
//   A hit, a flush or a miss served from a free frame passes from acceptance
//   through the decide and finish states to a valid result. A miss that must
//   evict walks the last-use memory one entry per cycle (32 entries plus one
//   compare stage), then reads the victim's frame and evicts it. The block
//   returns to idle on the same edge that loads the result.
//   in_stall is high while a transaction is in progress.
//   A stalled result sits in the output register; the next transaction is
//   still accepted and processed, and waits at its final step only until
//   the output register frees.
//   Reset empties the page table, clears all counters and sets the frame
//   count to 4.
// ----------------------------------------------------------------------------
module lru_page_frame_manager #(
  parameter int TIME_BITS = lrupf_pkg::TIME_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  lrupf_pkg::in_item_t         in_data,
  output logic                        out_valid,
  input  wire                         out_stall,
  output lrupf_pkg::out_item_t        out_data,
  input  wire                         cfg_write,
  input  wire [lrupf_pkg::CFG_W-1:0]  cfg_data
);
  import lrupf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       idle;

  assign in_stall = !idle;

  // Controller.
  lrupf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .idle     (idle),
    .cmd      (cmd)
  );

  // Datapath.
  lrupf_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // One transaction at a time: acceptance closes the input.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // A hit never evicts another page.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.hit) |-> !out_data.evicted_valid)
    else $error("eviction reported on a hit");

  // Without an eviction the evicted page field reads zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.evicted_valid) |-> (out_data.evicted_page == '0))
    else $error("evicted page set without eviction");

endmodule : lru_page_frame_manager
`default_nettype wire

@@ sim/lrupf_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame manager scoreboard
// Mirrors the page table of the LRU page frame manager, predicts one result
// per accepted transaction and compares results from the block in order.
// ----------------------------------------------------------------------------
package lrupf_scoreboard_pkg;
  import lrupf_pkg::*;

  class page_frame_scoreboard;
    // Mirror of the page table, counters and frame count register.
    bit [VIRTUAL_PAGES-1:0] resident;
    logic [FRAME_W-1:0]     frame_of [VIRTUAL_PAGES];
    bit [31:0]              last_use [VIRTUAL_PAGES];
    bit [FREE_W-1:0]        next_free;
    bit [31:0]              use_clock;
    bit [MISS_W-1:0]        misses;
    bit [CFG_W-1:0]         frames_cfg;

    // Predicted results waiting for the block, oldest first.
    out_item_t expected_results[$];

    int mismatches;
    int results_seen;
    int hits_seen;
    int evictions_seen;
    int flushes_seen;

    function new();
      clear_table();
      frames_cfg = FRAMES_RESET;
    endfunction

    function void clear_table();
      resident  = '0;
      next_free = '0;
      use_clock = '0;
      misses    = '0;
      foreach (frame_of[i]) begin
        frame_of[i] = '0;
        last_use[i] = '0;
      end
    endfunction

    function void set_frames(bit [CFG_W-1:0] value);
      frames_cfg = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Applies one accepted transaction to the mirror and queues its result.
    function void note_request(in_item_t req);
      out_item_t    res;
      int           limit;
      bit           found;
      int           victim;
      bit [31:0]    oldest;
      logic [PAGE_W-1:0] pg;
      res = '0;
      if (req.operation == OP_FLUSH) begin
        clear_table();
        flushes_seen++;
        expected_results.push_back(res);
        return;
      end
      pg = req.page_number;
      if (resident[pg]) begin
        res.hit = 1'b1;
        res.frame_number = frame_of[pg];
        hits_seen++;
      end else begin
        if (misses != '1) misses++;
        // A frame count of zero acts as one; counts above the pool are clipped.
        limit = (frames_cfg == 0) ? 1 : ((frames_cfg > MAX_FRAMES) ? MAX_FRAMES : frames_cfg);
        if (next_free < limit) begin
          res.frame_number = next_free[FRAME_W-1:0];
          next_free++;
        end else begin
          // Oldest resident page loses its frame; the lowest index wins a tie.
          found  = 1'b0;
          victim = 0;
          oldest = '0;
          for (int j = 0; j < VIRTUAL_PAGES; j++) begin
            if (resident[j] && (!found || last_use[j] < oldest)) begin
              found  = 1'b1;
              oldest = last_use[j];
              victim = j;
            end
          end
          if (found) begin
            res.frame_number  = frame_of[victim];
            res.evicted_valid = 1'b1;
            res.evicted_page  = victim[PAGE_W-1:0];
            resident[victim]  = 1'b0;
            evictions_seen++;
          end
        end
        resident[pg] = 1'b1;
        frame_of[pg] = res.frame_number;
      end
      last_use[pg] = use_clock;
      if (use_clock != '1) use_clock++;
      res.miss_total = misses;
      expected_results.push_back(res);
    endfunction

    function string show(out_item_t r);
      return $sformatf("hit=%0d frame=%0d evicted=%0d/%0d misses=%0d", r.hit,
                       r.frame_number, r.evicted_valid, r.evicted_page, r.miss_total);
    endfunction

    // Compares one result from the block with the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t want;
      bit        bad;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: %s", $time, show(got));
        return;
      end
      want = expected_results.pop_front();
      bad = (got.hit !== want.hit) || (got.frame_number !== want.frame_number) ||
            (got.evicted_valid !== want.evicted_valid) ||
            (got.evicted_page !== want.evicted_page) ||
            (got.miss_total !== want.miss_total);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result %0d mismatch\n  expected %s\n  actual   %s", $time,
                   results_seen, show(want), show(got));
      end
    endfunction
  endclass

endpackage : lrupf_scoreboard_pkg

@@ sim/tb_lru_page_frame_manager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page frame manager testbench
// Drives page accesses and flushes under several frame counts with random
// idling on both channels and a long output hold-off, and checks every
// result against a mirrored page table.
// ----------------------------------------------------------------------------
module tb_lru_page_frame_manager;
  import lrupf_pkg::*;
  import lrupf_scoreboard_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_write;
  logic [CFG_W-1:0] cfg_data;

  page_frame_scoreboard book = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int frame_settings = 0;

  lru_page_frame_manager dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Check every result transaction that the receiver takes.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) book.check_result(out_data);
  end

  // Receiver pacing: random stalls, or a long hold-off when one is requested.
  initial begin : receiver_pacing
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offers one transaction and returns once the block has accepted it.
  task automatic send_item(input in_item_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_request(req);
  endtask

  task automatic send_access(input logic [PAGE_W-1:0] page);
    in_item_t req;
    req.operation   = OP_ACCESS;
    req.page_number = page;
    send_item(req);
  endtask

  task automatic send_flush();
    in_item_t req;
    req.operation   = OP_FLUSH;
    req.page_number = PAGE_W'($urandom_range(VIRTUAL_PAGES - 1));
    send_item(req);
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    book.set_frames(value);
    frame_settings++;
  endtask

  // Watchdog against a hung handshake.
  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] chunk_frames [6];
    int eff;
    int base;
    int span;
    chunk_frames = '{6'd1, 6'd4, 6'd32, 6'd63, 6'd0, 6'd7};

    clk       = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_data  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Reset frame count of four: fill, hit, evict the oldest, then flush.
    send_access(5'd0);
    send_access(5'd31);
    send_access(5'd5);
    send_access(5'd10);
    send_access(5'd31);
    send_access(5'd20);
    send_access(5'd0);
    send_flush();
    send_access(5'd31);

    // A frame count of zero behaves as a single frame.
    write_frames(6'd0);
    send_access(5'd3);
    send_access(5'd3);
    send_access(5'd7);

    // An oversized frame count is clipped; then the count is lowered while
    // frames above the new limit are still mapped.
    write_frames(6'd63);
    send_flush();
    for (int p = 0; p < 6; p++) send_access(PAGE_W'(p * 5));
    write_frames(6'd2);
    send_access(5'd1);
    send_access(5'd2);
    send_access(5'd25);

    // Random traffic over several frame counts and idling patterns.
    for (int c = 0; c < 6; c++) begin
      write_frames(chunk_frames[c]);
      send_idle_pct = (c < 2) ? 6 : ((c < 4) ? 59 : 0);
      recv_idle_pct = (c < 2) ? 59 : ((c < 4) ? 6 : 0);
      eff  = (chunk_frames[c] == 0) ? 1 :
             ((chunk_frames[c] > MAX_FRAMES) ? MAX_FRAMES : chunk_frames[c]);
      base = $urandom_range(VIRTUAL_PAGES - 1);
      span = eff + 3;
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(99) < 3)
          send_flush();
        else if ($urandom_range(99) < 70)
          send_access(PAGE_W'((base + $urandom_range(span - 1)) % VIRTUAL_PAGES));
        else
          send_access(PAGE_W'($urandom_range(VIRTUAL_PAGES - 1)));
      end
    end

    // Long output hold-off while the sender keeps offering transactions.
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (int i = 0; i < 16; i++) send_access(PAGE_W'($urandom_range(VIRTUAL_PAGES - 1)));

    drain();
    repeat (40) @(posedge clk);

    $display("Covered %0d transactions under %0d frame count writes: %0d hits, %0d evictions,",
             book.results_seen, frame_settings, book.hits_seen, book.evictions_seen);
    $display("%0d flushes, %0d mismatching results.", book.flushes_seen, book.mismatches);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/lrupf_pkg.sv
src/lrupf_ctrl.sv
src/lrupf_dp.sv
src/lru_page_frame_manager.sv
sim/lrupf_scoreboard_pkg.sv
sim/tb_lru_page_frame_manager.sv
